// ----- rtl/srms_pkg.sv -----
package srms_pkg;

    // defaults for the top level parameters
    localparam int MAX_ROWS_D    = 64;
    localparam int MAX_ENTRIES_D = 1024;

    // column bound is fixed by the 6-bit column field
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 7;
    localparam int STAT_W = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TUSER_W = 2;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam int Q_DEPTH = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // one request on its way from the front to the back
    typedef struct packed {
        t_cmd              cmd;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic              decided;
        t_status           status;
    } t_qitem;

endpackage

// ----- rtl/sparse_row_matrix_store.sv -----
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// s_       | in        | s_tvalid/s_tready  | tdata: row, col, value; tuser: command
// m_       | out       | m_tvalid/m_tready  | tdata: read_value; tuser: status
// apb      | in        | psel/penable       | num_rows (0x0), num_cols (0x4)
//
// An insert updates each row end pointer from row+1 up to the rows in use, one at a
// time through the single pointer RAM write port. A lookup scans the n entries of the
// row with one entry RAM read per cycle; errors and zero inserts go straight to the
// result without writing the RAMs. After reset a clearing pass zeroes all MAX_ROWS+1
// pointer RAM words with s_tready low. A two-deep request queue and the output
// register let the input side keep accepting while a result waits.
module sparse_row_matrix_store #(
    parameter int MAX_ROWS    = srms_pkg::MAX_ROWS_D,
    parameter int MAX_ENTRIES = srms_pkg::MAX_ENTRIES_D
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srms_pkg::PADDR_W-1:0]      paddr,
    input  logic [srms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] row_index, [11:6] col_index, [43:12] elem_value, [47:44] zero
    input  logic [srms_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic [srms_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] read_value
    output logic [srms_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [srms_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import srms_pkg::*;

    localparam int RAW = $clog2(MAX_ROWS + 1);

    logic            clearing;
    logic            q_full;
    logic            push;
    t_qitem          push_item;
    logic [RAW-1:0]  rows;
    logic            q_valid;
    t_qitem          q_item;
    logic            q_pop;

    assign pready = 1'b1;

    srms_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (push_item),
        .o_rows     (rows)
    );

    srms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    srms_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rows       (rows),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_read_value (m_tdata),
        .o_status     (m_tuser)
    );

endmodule

// ----- rtl/srms_ram.sv -----
module srms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/srms_front.sv -----
module srms_front #(
    parameter int MAX_ROWS = srms_pkg::MAX_ROWS_D,
    localparam int RAW = $clog2(MAX_ROWS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [srms_pkg::PADDR_W-1:0]      i_paddr,
    input  logic [srms_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [srms_pkg::APB_DATA_W-1:0]   o_prdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [srms_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic [srms_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    input  logic                              i_clearing,
    input  logic                              i_q_full,
    output logic                              o_push,
    output srms_pkg::t_qitem                  o_item,
    output logic [RAW-1:0]                    o_rows
);
    import srms_pkg::*;

    localparam int DW = (RAW > CFG_W) ? RAW : CFG_W;

    logic [CFG_W-1:0] r_num_rows;
    logic [CFG_W-1:0] r_num_cols;
    logic             wr_en;
    logic             reg_sel;
    logic [DW-1:0]    rows_c;
    logic [CFG_W-1:0] cols_c;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    t_cmd             cmd;
    logic             range_bad;

    assign reg_sel = i_paddr[2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_RESET;
            r_num_cols <= CFG_RESET;
        end else if (wr_en) begin
            if (reg_sel == REG_NUM_ROWS) begin
                r_num_rows <= i_pwdata[CFG_W-1:0];
            end else begin
                r_num_cols <= i_pwdata[CFG_W-1:0];
            end
        end
    end

    assign o_prdata = (reg_sel == REG_NUM_ROWS) ? APB_DATA_W'(r_num_rows)
                                                : APB_DATA_W'(r_num_cols);

    // clamp the dimensions in use to 1..max
    always_comb begin
        priority if (r_num_rows == '0) begin
            rows_c = DW'(1);
        end else if (DW'(r_num_rows) > DW'(MAX_ROWS)) begin
            rows_c = DW'(MAX_ROWS);
        end else begin
            rows_c = DW'(r_num_rows);
        end
        priority if (r_num_cols == '0) begin
            cols_c = CFG_W'(1);
        end else if (r_num_cols > CFG_W'(MAX_COLS)) begin
            cols_c = CFG_W'(MAX_COLS);
        end else begin
            cols_c = r_num_cols;
        end
    end

    assign o_rows = RAW'(rows_c);

    assign row   = i_s_tdata[ROW_W-1:0];
    assign col   = i_s_tdata[ROW_W+COL_W-1:ROW_W];
    assign value = i_s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
    assign cmd   = t_cmd'(i_s_tuser[0]);

    assign range_bad = (DW'(row) >= rows_c) || (CFG_W'(col) >= cols_c);

    assign o_s_tready = !i_clearing && !i_q_full;
    assign o_push     = i_s_tvalid && o_s_tready;

    // range errors and zero inserts are settled here; the back only answers them
    always_comb begin
        o_item.cmd     = cmd;
        o_item.row     = row;
        o_item.col     = col;
        o_item.value   = value;
        o_item.decided = range_bad || (cmd == CMD_INSERT && value == '0);
        o_item.status  = range_bad ? ST_RANGE : ST_OK;
    end

endmodule

// ----- rtl/srms_queue.sv -----
module srms_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srms_pkg::t_qitem  i_item,
    output logic              o_full,
    output logic              o_valid,
    output srms_pkg::t_qitem  o_item,
    input  logic              i_pop
);
    import srms_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_qitem           r_slot [Q_DEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/srms_back.sv -----
module srms_back #(
    parameter int MAX_ROWS    = srms_pkg::MAX_ROWS_D,
    parameter int MAX_ENTRIES = srms_pkg::MAX_ENTRIES_D,
    localparam int RAW = $clog2(MAX_ROWS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [RAW-1:0]                    i_rows,
    input  logic                              i_q_valid,
    input  srms_pkg::t_qitem                  i_q_item,
    output logic                              o_q_pop,
    output logic                              o_clearing,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [srms_pkg::VAL_W-1:0]        o_read_value,
    output logic [srms_pkg::STAT_W-1:0]       o_status
);
    import srms_pkg::*;

    localparam int PW  = $clog2(MAX_ENTRIES + 1);
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW  = COL_W + VAL_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SWEEP,
        S_LK_START,
        S_LK_END,
        S_SCAN,
        S_RESP
    } t_state;

    t_state           r_state;
    t_qitem           r_item;
    logic [RAW-1:0]   r_addr;
    logic [PW-1:0]    r_count;
    logic [ROW_W-1:0] r_last_row;
    logic [PW-1:0]    r_start;
    logic [PW-1:0]    r_end;
    logic [PW-1:0]    r_k;
    logic             r_pend;
    logic [VAL_W-1:0] r_res_value;
    t_status          r_res_status;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    t_status          r_out_status;

    logic             ptr_we;
    logic [RAW-1:0]   ptr_raddr;
    logic [PW-1:0]    ptr_wdata;
    logic [PW-1:0]    ptr_rdata;
    logic             ent_we;
    logic [EW-1:0]    ent_rdata;
    logic             order_bad;
    logic             store_full;
    logic [PW-1:0]    end_lim;
    logic             scan_hit;
    logic             out_free;

    assign order_bad  = (r_item.row < r_last_row);
    assign store_full = (r_count == PW'(MAX_ENTRIES));
    assign end_lim    = (ptr_rdata < r_count) ? ptr_rdata : r_count;
    assign scan_hit   = r_pend && (ent_rdata[EW-1:VAL_W] == r_item.col);
    assign out_free   = !r_out_valid || i_m_tready;

    // row pointer port: clear pass, read-modify-write sweep, or row bounds
    always_comb begin
        ptr_we    = (r_state == S_CLEAR) || (r_state == S_SWEEP);
        ptr_wdata = (r_state == S_CLEAR) ? '0 : PW'(ptr_rdata + PW'(1));
        unique case (r_state)
            S_DISPATCH: ptr_raddr = (r_item.cmd == CMD_INSERT) ?
                                    RAW'(r_item.row) + RAW'(1) : RAW'(r_item.row);
            S_LK_START: ptr_raddr = RAW'(r_item.row) + RAW'(1);
            S_SWEEP:    ptr_raddr = r_addr + RAW'(1);
            default:    ptr_raddr = r_addr;
        endcase
    end

    assign ent_we = (r_state == S_DISPATCH) && !r_item.decided &&
                    (r_item.cmd == CMD_INSERT) && !order_bad && !store_full;

    srms_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ROWS + 1)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (r_addr),
        .i_wdata (ptr_wdata),
        .i_raddr (ptr_raddr),
        .o_rdata (ptr_rdata)
    );

    srms_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_count[EAW-1:0]),
        .i_wdata ({r_item.col, r_item.value}),
        .i_raddr (r_k[EAW-1:0]),
        .o_rdata (ent_rdata)
    );

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_last_row  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, else drop the one just taken
            if (r_state == S_RESP && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= r_res_value;
                r_out_status <= r_res_status;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + RAW'(1);
                    if (r_addr == RAW'(MAX_ROWS)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res_value <= '0;
                    priority if (r_item.decided) begin
                        r_res_status <= r_item.status;
                        r_state      <= S_RESP;
                    end else if (r_item.cmd == CMD_LOOKUP) begin
                        r_res_status <= ST_OK;
                        r_state      <= S_LK_START;
                    end else if (order_bad) begin
                        r_res_status <= ST_ORDER;
                        r_state      <= S_RESP;
                    end else if (store_full) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_RESP;
                    end else begin
                        r_res_status <= ST_OK;
                        r_count      <= r_count + PW'(1);
                        r_last_row   <= r_item.row;
                        r_addr       <= RAW'(r_item.row) + RAW'(1);
                        r_state      <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    // advance every row end from row+1 up to the rows in use
                    if (r_addr == i_rows) begin
                        r_state <= S_RESP;
                    end else begin
                        r_addr <= r_addr + RAW'(1);
                    end
                end
                S_LK_START: begin
                    r_start <= ptr_rdata;
                    r_state <= S_LK_END;
                end
                S_LK_END: begin
                    r_end   <= end_lim;
                    r_k     <= r_start;
                    r_pend  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // compare the entry read last cycle while fetching the next
                    priority if (scan_hit) begin
                        r_res_value <= ent_rdata[VAL_W-1:0];
                        r_pend      <= 1'b0;
                        r_state     <= S_RESP;
                    end else if (r_k < r_end) begin
                        r_k    <= r_k + PW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_clearing   = (r_state == S_CLEAR);
    assign o_m_tvalid   = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

// ----- rtl/srms_checker.sv -----
module srms_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [srms_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic [srms_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import srms_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // any error status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error result with nonzero value");

    // no request is taken right out of reset, while the pointer store is being cleared
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_tready)
        else $error("input ready during clearing pass");

    // no result straight out of reset
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sparse_row_matrix_store srms_checker u_srms_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
